[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants for the rational arithmetic unit: opcodes, status codes,
// default data width.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // opcodes
  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_LESS = 3'd5;
  localparam logic [2:0] OP_EQ   = 3'd6;
  localparam logic [2:0] OP_ALT  = 3'd7;  // behaves as normalize

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // where the reduce routine returns to
  typedef enum logic [1:0] {
    RET_A = 2'd0,
    RET_B = 2'd1,
    RET_F = 2'd2
  } ret_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction arithmetic with GCD reduction on one shared shift/add unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_*): opcode in s_tuser, four signed operands in s_tdata.
//   Output beat (m_*): reduced result in m_tdata, compare flag and status in
//   m_tuser. Exactly one output beat per input beat, in order.
// Operation: each operand is reduced by its Euclidean GCD, then combined
//   (add/sub/mul/div/less/equal); an add/sub/mul/div result is reduced
//   again; it, like a normalize result, is checked against the DATA_WIDTH-bit range.
// Work: all multiply, divide and modulo work runs on one bit-serial unit
//   of 2*DATA_WIDTH bits. An item takes (E + 2*R + M) uses of it, where E
//   is the total number of Euclid modulo steps, R the number of nonzero
//   reductions (up to 3) and M is 3 when the cross products are formed
//   (add, sub, mul, div, less), else 0. A zero denominator result is
//   valid the cycle after its input beat.
// Throughput: one item at a time; s_tready is high only when idle.
// Reset: rst (synchronous, active high) returns to idle, output invalid.
// Stall: a result is held on m_* until m_tready; no new beat is taken
//   until the result has been delivered.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // res_num[31:0], res_den[62:32], zero pad
  output logic [2:0]   m_tuser    // compare_true, status[2:1]
);
  import rau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int W  = 2 * DW;           // width of products and sums
  localparam int CW = $clog2(W + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_RED  = 12'b000000000010,  // reduce entry
    S_GCD  = 12'b000000000100,  // Euclid loop head
    S_GMOD = 12'b000000001000,  // wait on modulo
    S_DIVN = 12'b000000010000,  // numerator / g
    S_DIVD = 12'b000000100000,  // denominator / g
    S_RET  = 12'b000001000000,  // reduce return dispatch
    S_MUL1 = 12'b000010000000,
    S_MUL2 = 12'b000100000000,
    S_MUL3 = 12'b001000000000,
    S_COMB = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;
  logic   out_valid;
  ret_t   ret;
  logic [2:0] op;

  // operands (sign and magnitude)
  logic          aneg, bneg;
  logic [DW-1:0] an, ad, bn, bd;
  // working fraction and Euclid pair
  logic          rneg;
  logic [W-1:0]  rn, rd, gx, gy;
  logic          gsel;
  logic [W-1:0]  t1, t2, den;

  // shared bit-serial multiply/divide unit
  logic [W:0]    u_rem;
  logic [W-1:0]  u_q, u_y;
  logic [CW-1:0] u_cnt;
  logic          u_mul;
  logic [W:0]    u_sh, u_rem_next;
  logic [W-1:0]  u_q_next;
  logic          u_done;

  // output registers
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        compare_true;
  logic [1:0]  status;

  // input split
  logic [DW-1:0] in_an, in_ad, in_bn, in_bd;
  logic [DW-1:0] mag_an, mag_ad, mag_bn, mag_bd;
  logic          in_uses_b, in_zden;

  // combine
  logic          c_same, c_ge, c_neg;
  logic [W-1:0]  c_sum;
  logic          is_prod;

  // fit check
  logic [W-1:0]  half;
  logic          fits;
  logic [DW-1:0] out_num;

  assign in_an = s_tdata[DW-1:0];
  assign in_ad = s_tdata[32+DW-1:32];
  assign in_bn = s_tdata[64+DW-1:64];
  assign in_bd = s_tdata[96+DW-1:96];
  assign mag_an = in_an[DW-1] ? DW'(-in_an) : in_an;
  assign mag_ad = in_ad[DW-1] ? DW'(-in_ad) : in_ad;
  assign mag_bn = in_bn[DW-1] ? DW'(-in_bn) : in_bn;
  assign mag_bd = in_bd[DW-1] ? DW'(-in_bd) : in_bd;
  assign in_uses_b = (s_tuser != OP_NORM) && (s_tuser != OP_ALT);
  assign in_zden = (in_ad == '0) || (in_uses_b && (in_bd == '0));

  // one step of shift/add multiply or restoring divide
  assign u_sh = u_mul ? {u_rem[W-1:0], 1'b0} : {u_rem[W-1:0], u_q[W-1]};
  always_comb begin
    u_q_next = {u_q[W-2:0], 1'b0};
    if (u_mul) begin
      u_rem_next = u_q[W-1] ? (u_sh + {1'b0, u_y}) : u_sh;
    end else if (u_sh >= {1'b0, u_y}) begin
      u_rem_next = u_sh - {1'b0, u_y};
      u_q_next   = {u_q[W-2:0], 1'b1};
    end else begin
      u_rem_next = u_sh;
    end
  end
  assign u_done = (u_cnt == '0);

  assign is_prod = (op == OP_MUL) || (op == OP_DIV);
  assign c_same  = (aneg == bneg);
  assign c_ge    = (t1 >= t2);
  assign c_sum   = c_same ? (t1 + t2) : (c_ge ? (t1 - t2) : (t2 - t1));
  assign c_neg   = (c_same || c_ge) ? aneg : bneg;

  assign half    = W'(1) << (DW - 1);
  assign fits    = (rd <= half - 1'b1) && (rneg ? (rn <= half) : (rn <= half - 1'b1));
  assign out_num = rneg ? DW'(-rn) : rn[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      u_cnt     <= '0;
    end else begin
      if (!u_done) begin
        u_rem <= u_rem_next;
        u_q   <= u_q_next;
        u_cnt <= u_cnt - 1'b1;
      end
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && !out_valid) begin
            op           <= s_tuser;
            compare_true <= 1'b0;
            res_num      <= '0;
            res_den      <= 31'd1;
            if (in_zden) begin
              status    <= ST_ZDEN;
              out_valid <= 1'b1;
            end else begin
              status <= ST_OK;
              rn     <= W'(mag_an);
              rd     <= W'(mag_ad);
              rneg   <= in_an[DW-1] ^ in_ad[DW-1];
              bn     <= mag_bn;
              bd     <= mag_bd;
              bneg   <= in_bn[DW-1] ^ in_bd[DW-1];
              ret    <= RET_A;
              state  <= S_RED;
            end
          end
        end
        S_RED: begin
          if ((rn == '0) || (rd == '0)) begin
            rn    <= '0;
            rd    <= W'(1);
            rneg  <= 1'b0;
            state <= S_RET;
          end else begin
            gx    <= rn;
            gy    <= rd;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          u_rem <= '0;
          u_cnt <= CW'(W);
          u_mul <= 1'b0;
          if ((gx == '0) || (gy == '0)) begin
            u_q   <= rn;
            u_y   <= gx | gy;
            state <= S_DIVN;
          end else if (gx > gy) begin
            u_q   <= gx;
            u_y   <= gy;
            gsel  <= 1'b0;
            state <= S_GMOD;
          end else begin
            u_q   <= gy;
            u_y   <= gx;
            gsel  <= 1'b1;
            state <= S_GMOD;
          end
        end
        S_GMOD: begin
          if (u_done) begin
            if (gsel) gy <= u_rem[W-1:0];
            else      gx <= u_rem[W-1:0];
            state <= S_GCD;
          end
        end
        S_DIVN: begin
          if (u_done) begin
            rn    <= u_q;
            u_rem <= '0;
            u_q   <= rd;          // divisor g stays in u_y
            u_cnt <= CW'(W);
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (u_done) begin
            rd    <= u_q;
            state <= S_RET;
          end
        end
        S_RET: begin
          unique case (ret)
            RET_A: begin
              an   <= rn[DW-1:0];
              ad   <= rd[DW-1:0];
              aneg <= rneg;
              if ((op == OP_NORM) || (op == OP_ALT)) begin
                state <= S_FIN;
              end else begin
                rn    <= W'(bn);
                rd    <= W'(bd);
                rneg  <= bneg;
                ret   <= RET_B;
                state <= S_RED;
              end
            end
            RET_B: begin
              bn   <= rn[DW-1:0];
              bd   <= rd[DW-1:0];
              bneg <= rneg ^ ((op == OP_SUB) || (op == OP_LESS));
              if (op == OP_EQ) begin
                compare_true <= (aneg == rneg) && (an == rn[DW-1:0]) && (ad == rd[DW-1:0]);
                out_valid    <= 1'b1;
                state        <= S_IDLE;
              end else if ((op == OP_DIV) && (rn == '0)) begin
                status    <= ST_DIV0;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end else begin
                u_rem <= '0;
                u_q   <= W'(an);
                u_y   <= (op == OP_MUL) ? rn : rd;
                u_cnt <= CW'(W);
                u_mul <= 1'b1;
                state <= S_MUL1;
              end
            end
            RET_F: begin
              state <= S_FIN;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_MUL1: begin
          if (u_done) begin
            t1    <= u_rem[W-1:0];
            u_rem <= '0;
            u_q   <= W'(bn);
            u_y   <= W'(ad);
            u_cnt <= CW'(W);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (u_done) begin
            t2    <= u_rem[W-1:0];
            u_rem <= '0;
            u_q   <= W'(ad);
            u_y   <= (op == OP_DIV) ? W'(bn) : W'(bd);
            u_cnt <= CW'(W);
            state <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (u_done) begin
            den   <= u_rem[W-1:0];
            state <= S_COMB;
          end
        end
        S_COMB: begin
          ret <= RET_F;
          rd  <= den;
          if (is_prod) begin
            rn    <= t1;
            rneg  <= aneg ^ bneg;
            state <= S_RED;
          end else if (op == OP_LESS) begin
            compare_true <= c_neg && (c_sum != '0);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            rn    <= c_sum;
            rneg  <= c_neg;
            state <= S_RED;
          end
        end
        S_FIN: begin
          if (fits) begin
            res_num <= 32'($signed(out_num));
            res_den <= 31'(rd[DW-1:0]);
          end else begin
            status <= ST_OVF;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, res_den, res_num};
  assign m_tuser  = {status, compare_true};

endmodule

[rtl/rau_check.sv]
// ----------------------------------------------------------------------------
// rau_check
// Port-level checks for the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [127:0] s_tdata,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [2:0]   m_tuser
);
  import rau_pkg::*;

  // one item in flight: never ready while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // an accepted beat blocks the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

  // any error status delivers 0/1 and no compare flag
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:1] != ST_OK)) |->
      (m_tdata[31:0] == 32'd0) && (m_tdata[62:32] == 31'd1) && !m_tuser[0])
    else $error("error result not 0/1");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit rau_check u_rau_check (.*);
